/* hdl/three_class_priority_queue_defines.svh */
// Assertion macros for the three-class priority queue.
// Included by the top level; depends on nothing else.
`ifndef THREE_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tcpq_pkg.sv */
// Shared types and constants for the three-class priority queue.
// No dependencies; used by the top level for codes, widths and defaults.
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;
    localparam int CLASS_COUNT     = 3;
    localparam int CLASS_W         = 2;
    localparam int STATUS_W        = 3;
    localparam int OP_W            = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 1'b0,
        OP_SERVE   = 1'b1
    } op_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_RED     = 2'd0,
        CLS_YELLOW  = 2'd1,
        CLS_GREEN   = 2'd2,
        CLS_INVALID = 2'd3
    } class_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_SERVED    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_CLASS = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

endpackage

/* hdl/three_class_priority_queue.sv */
// Three-class strict priority queue: per-class FIFOs of tags in RAM.
// A transaction's result is registered in stage 1, then in the output register.
// Throughput: one transaction per cycle while the output is not stalled; the tag RAM read port sets the extra stage.
// Reset clears pointers, fill counts and pipeline valids at once; the tag
// RAMs are not cleared (no slot is read before it is written).
`include "three_class_priority_queue_defines.svh"

module three_class_priority_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcpq_pkg::TAG_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // priority_class [1:0], item_tag [TAG_BITS+1:2], zero fill above
    input  logic [((TAG_BITS + tcpq_pkg::CLASS_W + 7) / 8) * 8 - 1:0] s_tdata,
    // operation [0]
    input  logic [tcpq_pkg::OP_W-1:0]               s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // served_tag [TAG_BITS-1:0], served_class [TAG_BITS+1:TAG_BITS], zero fill above
    output logic [((TAG_BITS + tcpq_pkg::CLASS_W + 7) / 8) * 8 - 1:0] m_tdata,
    // status [2:0]
    output logic [tcpq_pkg::STATUS_W-1:0]           m_tuser
);

    import tcpq_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W = ((TAG_BITS + CLASS_W + 7) / 8) * 8;

    logic [PTR_W-1:0] rd_idx_reg   [CLASS_COUNT];
    logic [PTR_W-1:0] rd_idx_next  [CLASS_COUNT];
    logic [PTR_W-1:0] wr_idx_reg   [CLASS_COUNT];
    logic [PTR_W-1:0] wr_idx_next  [CLASS_COUNT];
    logic [CNT_W-1:0] fill_reg     [CLASS_COUNT];
    logic [CNT_W-1:0] fill_next    [CLASS_COUNT];
    logic [TAG_BITS-1:0] ram_rdata [CLASS_COUNT];

    logic [CLASS_COUNT-1:0] full;
    logic [CLASS_COUNT-1:0] nonempty;
    logic [CLASS_COUNT-1:0] pick;
    logic [CLASS_COUNT-1:0] enq_hit;
    logic [CLASS_COUNT-1:0] deq_hit;

    logic                accept;
    op_t                 in_op;
    class_t              in_class;
    logic [TAG_BITS-1:0] in_tag;
    status_t             status_now;
    logic [CLASS_W-1:0]  pick_class;
    logic                class_ok;
    logic                class_full;

    // Stage 1: decision made, waiting for the RAM read data
    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic [CLASS_W-1:0] s1_class_reg;
    logic               s1_adv;

    // Output register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [TAG_BITS-1:0] s1_tag;

    assign in_op    = op_t'(s_tuser);
    assign in_class = class_t'(s_tdata[CLASS_W-1:0]);
    assign in_tag   = s_tdata[CLASS_W +: TAG_BITS];

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            full[c]     = (fill_reg[c] == CNT_W'(QUEUE_DEPTH));
            nonempty[c] = (fill_reg[c] != '0);
        end
        // strict priority: lowest class number wins
        pick[0] = nonempty[0];
        pick[1] = !nonempty[0] && nonempty[1];
        pick[2] = !nonempty[0] && !nonempty[1] && nonempty[2];
    end

    always_comb
    begin
        class_ok   = (in_class != CLS_INVALID);
        class_full = 1'b0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (in_class == class_t'(c))
            begin
                class_full = full[c];
            end
        end

        priority if (pick[0])
        begin
            pick_class = CLS_RED;
        end
        else if (pick[1])
        begin
            pick_class = CLS_YELLOW;
        end
        else if (pick[2])
        begin
            pick_class = CLS_GREEN;
        end
        else
        begin
            pick_class = CLS_RED;
        end

        unique case (in_op)
            OP_ENQUEUE:
            begin
                priority if (!class_ok)
                begin
                    status_now = ST_BAD_CLASS;
                end
                else if (class_full)
                begin
                    status_now = ST_FULL;
                end
                else
                begin
                    status_now = ST_ADDED;
                end
            end
            OP_SERVE:
            begin
                status_now = (|nonempty) ? ST_SERVED : ST_EMPTY;
            end
            default:
            begin
                status_now = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            enq_hit[c] = accept && (in_op == OP_ENQUEUE) && (in_class == class_t'(c))
                         && !full[c];
            deq_hit[c] = accept && (in_op == OP_SERVE) && pick[c];

            wr_idx_next[c] = wr_idx_reg[c];
            rd_idx_next[c] = rd_idx_reg[c];
            fill_next[c]   = fill_reg[c];
            if (enq_hit[c])
            begin
                wr_idx_next[c] = (wr_idx_reg[c] == PTR_W'(QUEUE_DEPTH - 1))
                                 ? '0 : wr_idx_reg[c] + PTR_W'(1);
                fill_next[c]   = fill_reg[c] + CNT_W'(1);
            end
            if (deq_hit[c])
            begin
                rd_idx_next[c] = (rd_idx_reg[c] == PTR_W'(QUEUE_DEPTH - 1))
                                 ? '0 : rd_idx_reg[c] + PTR_W'(1);
                fill_next[c]   = fill_reg[c] - CNT_W'(1);
            end
        end
    end

    for (genvar g = 0; g < CLASS_COUNT; g++)
    begin : g_class_ram
        tcpq_ram #(
            .WIDTH (TAG_BITS),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (enq_hit[g]),
            .wr_addr (wr_idx_reg[g]),
            .wr_data (in_tag),
            .rd_en   (deq_hit[g]),
            .rd_addr (rd_idx_reg[g]),
            .rd_data (ram_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                rd_idx_reg[c] <= '0;
                wr_idx_reg[c] <= '0;
                fill_reg[c]   <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                rd_idx_reg[c] <= rd_idx_next[c];
                wr_idx_reg[c] <= wr_idx_next[c];
                fill_reg[c]   <= fill_next[c];
            end
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Pick the served tag from the RAM that was read; zero for any other status
    always_comb
    begin
        s1_tag = '0;
        if (s1_status_reg == ST_SERVED)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                if (s1_class_reg == CLASS_W'(c))
                begin
                    s1_tag = ram_rdata[c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_now;
            s1_class_reg  <= (status_now == ST_SERVED) ? pick_class : CLASS_W'(CLS_RED);
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_class_reg  <= s1_class_reg;
            out_tag_reg    <= s1_tag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = DATA_W'({out_class_reg, out_tag_reg});

    `TCPQ_ASSERT_NEXT(a_serve_hit, clk, rst_n,
        accept && (in_op == OP_SERVE) && (|nonempty),
        s1_valid_reg && (s1_status_reg == ST_SERVED), "serve with waiting tags not served")

    `TCPQ_ASSERT_NEXT(a_serve_empty, clk, rst_n,
        accept && (in_op == OP_SERVE) && !(|nonempty),
        s1_valid_reg && (s1_status_reg == ST_EMPTY), "serve with no tags not reported empty")

    `TCPQ_ASSERT_NOW(a_unserved_zero, clk, rst_n,
        m_tvalid && (out_status_reg != ST_SERVED),
        (out_tag_reg == '0) && (out_class_reg == '0), "non-serve result carries tag or class")

endmodule

/* hdl/tcpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench for the three-class strict priority queue: directed, fill/drain,
// backpressure and random enqueue/serve traffic checked against a scoreboard.
// Depends on tcpq_pkg and three_class_priority_queue.
`timescale 1ns / 100ps

module tb_top;
    import tcpq_pkg::*;

    localparam int DEPTH   = QUEUE_DEPTH_DEF;
    localparam int TAG_W   = TAG_BITS_DEF;
    localparam int BUS_W   = ((TAG_W + CLASS_W + 7) / 8) * 8;
    localparam int FILL_W  = BUS_W - TAG_W - CLASS_W;

    typedef struct packed {
        status_t            status;
        logic [TAG_W-1:0]   tag;
        logic [CLASS_W-1:0] cls;
    } serve_outcome_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BUS_W-1:0]    s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BUS_W-1:0]    m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Scoreboard state: per-class ring of tags plus pending outcomes
    logic [TAG_W-1:0]    ring_tags [CLASS_COUNT][DEPTH];
    int                  ring_head [CLASS_COUNT];
    int                  ring_fill [CLASS_COUNT];
    serve_outcome_t      pending_outcomes[$];

    int                  mismatch_count = 0;
    int                  hold_cycles    = 0;
    bit                  burst_mode     = 1'b0;

    three_class_priority_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("[three_class_priority_queue] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_queue_outcome(input op_t op, input class_t cls,
                                         input logic [TAG_W-1:0] tag);
        serve_outcome_t res;
        bit             found;
        res.status = ST_EMPTY;
        res.tag    = '0;
        res.cls    = '0;
        found      = 1'b0;
        if (op == OP_ENQUEUE)
        begin
            if (cls == CLS_INVALID)
                res.status = ST_BAD_CLASS;
            else if (ring_fill[cls] >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                ring_tags[cls][(ring_head[cls] + ring_fill[cls]) % DEPTH] = tag;
                ring_fill[cls]++;
                res.status = ST_ADDED;
            end
        end
        else
        begin
            // strict priority: first non-empty class wins
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                if (!found && ring_fill[c] != 0)
                begin
                    res.status   = ST_SERVED;
                    res.tag      = ring_tags[c][ring_head[c]];
                    res.cls      = CLASS_W'(c);
                    ring_head[c] = (ring_head[c] + 1) % DEPTH;
                    ring_fill[c]--;
                    found        = 1'b1;
                end
            end
        end
        pending_outcomes.push_back(res);
    endtask

    // Offer one transaction after a random gap (none in burst mode); return once it is accepted.
    task automatic send_item(input op_t op, input class_t cls, input logic [TAG_W-1:0] tag);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{FILL_W{1'b0}}, tag, cls};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_queue_outcome(op, cls, tag);
    endtask

    task automatic send_random_serve();
        send_item(OP_SERVE, class_t'($urandom_range(0, 3)), TAG_W'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall before each transaction (none in burst mode), or a long hold on request.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = burst_mode ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && hold_cycles == 0)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        serve_outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result", 32'(m_tuser), '0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[TAG_W-1:0] !== want.tag)
                    report_mismatch("served_tag", 32'(m_tdata[TAG_W-1:0]), 32'(want.tag));
                if (m_tdata[TAG_W+CLASS_W-1:TAG_W] !== want.cls)
                    report_mismatch("served_class", 32'(m_tdata[TAG_W+CLASS_W-1:TAG_W]),
                                    32'(want.cls));
                if (m_tdata[BUS_W-1:TAG_W+CLASS_W] !== '0)
                    report_mismatch("tdata fill", 32'(m_tdata[BUS_W-1:TAG_W+CLASS_W]), '0);
            end
        end
    end

    // Empty serve, invalid class, every class, tag extremes, priority order.
    task automatic test_directed();
        send_item(OP_SERVE, CLS_INVALID, '1);
        send_item(OP_ENQUEUE, CLS_INVALID, '1);
        send_item(OP_ENQUEUE, CLS_GREEN, '0);
        send_item(OP_ENQUEUE, CLS_YELLOW, '1);
        send_item(OP_ENQUEUE, CLS_RED, 16'hA5A5);
        send_item(OP_ENQUEUE, CLS_RED, 16'h5A5A);
        send_item(OP_ENQUEUE, CLS_GREEN, '1);
        repeat (5) send_random_serve();
        send_item(OP_SERVE, CLS_RED, '0);
        send_item(OP_ENQUEUE, CLS_INVALID, '0);
        wait_drained();
    endtask

    // Fill one class past its depth, then drain everything including one empty serve.
    task automatic test_full_class();
        class_t fill_cls;
        fill_cls = class_t'($urandom_range(0, 2));
        for (int i = 0; i <= DEPTH; i++)
            send_item(OP_ENQUEUE, fill_cls, TAG_W'($urandom));
        send_item(OP_ENQUEUE, class_t'((fill_cls + 1) % CLASS_COUNT), TAG_W'($urandom));
        repeat (DEPTH + 2) send_random_serve();
        wait_drained();
    endtask

    // Hold the receiver off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        burst_mode  = 1'b1;
        hold_cycles = 80;
        for (int i = 0; i < 45; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_random_serve();
            else
                send_item(OP_ENQUEUE, class_t'($urandom_range(0, 2)), TAG_W'($urandom));
        end
        burst_mode = 1'b0;
        wait_drained();
    endtask

    // Phases biased to fill, drain or mix the queues; some phases run without idling.
    task automatic test_random_traffic(input int item_total);
        int sent;
        int phase_len;
        int enq_pct;
        sent = 0;
        while (sent < item_total)
        begin
            phase_len  = $urandom_range(20, 80);
            burst_mode = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       enq_pct = 80;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            for (int i = 0; i < phase_len; i++)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(OP_ENQUEUE, CLS_INVALID, TAG_W'($urandom));
                    else
                        send_item(OP_ENQUEUE, class_t'($urandom_range(0, 2)),
                                  TAG_W'($urandom));
                end
                else
                    send_random_serve();
            end
            sent += phase_len;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin : main
        int guard;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            ring_head[c] = 0;
            ring_fill[c] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_class();
        test_backpressure();
        test_random_traffic(1050);

        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_outcomes.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results still outstanding", pending_outcomes.size(), 0);

        if (mismatch_count == 0)
            $display("[three_class_priority_queue] OK");
        else
            $display("[three_class_priority_queue] ERROR");
        $finish;
    end

endmodule
